// File: src/hfpl_pkg.sv
// Package for the hashed friend pair lookup: transfer payload types, the
// front-to-back command type and the operation, kind and status codes.
// No dependencies.
package hfpl_pkg;

   localparam logic [1:0] OP_PERSON = 2'd0;
   localparam logic [1:0] OP_PAIR   = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] KIND_PERSON = 2'd0;
   localparam logic [1:0] KIND_PAIR   = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   localparam int         NAME_WORDS = 4;
   localparam logic [13:0] HASH_MUL  = 14'd10000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] person_id;
      logic [31:0] partner_id;
      logic [63:0] name_word;
      logic [1:0]  word_index;
      logic        which_name;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] status;
      logic       are_friends;
   } rsp_type;

   typedef struct packed {
      logic [1:0]   kind;
      logic [31:0]  person_id;
      logic [31:0]  partner_id;
      logic [255:0] name_a;
      logic [255:0] name_b;
   } cmd_type;

endpackage

// File: src/hfpl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hfpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/hfpl_queue.sv
// Two-entry command queue between the front and the back.
// Depends on hfpl_pkg.
module hfpl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hfpl_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             out_valid,
   output hfpl_pkg::cmd_type out_data
);

   hfpl_pkg::cmd_type ent_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= push_data;
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = ent_ff[rd_ff];

endmodule

// File: src/hfpl_front.sv
// Front part: accepts request transfers, assembles names and issues commands.
// Depends on hfpl_pkg.
module hfpl_front (
   input  logic              clock,
   input  logic              req_valid,
   output logic              req_stall,
   input  hfpl_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output hfpl_pkg::cmd_type q_data
);

   logic [63:0] nb_ff [8];
   logic [63:0] nb_in [8];
   logic        accept;
   logic        wr_en;
   logic [2:0]  wr_idx;
   logic        done;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      wr_en  = 1'b0;
      wr_idx = {1'b0, req_data.word_index};
      done   = 1'b0;
      q_data = '0;
      case (req_data.op)
         hfpl_pkg::OP_PERSON: begin
            wr_en = 1'b1;
            done  = (req_data.word_index == 2'd3);
         end
         hfpl_pkg::OP_PAIR: begin
            done = 1'b1;
         end
         hfpl_pkg::OP_QUERY: begin
            wr_en  = 1'b1;
            wr_idx = {req_data.which_name, req_data.word_index};
            done   = (req_data.word_index == 2'd3) && req_data.which_name;
         end
         default: begin
            done = 1'b0;
         end
      endcase
      for (int i = 0; i < 8; i++) begin
         nb_in[i] = nb_ff[i];
      end
      if (wr_en) begin
         nb_in[wr_idx] = req_data.name_word;
      end
      q_data.kind       = req_data.op;
      q_data.person_id  = req_data.person_id;
      q_data.partner_id = req_data.partner_id;
      q_data.name_a     = {nb_in[3], nb_in[2], nb_in[1], nb_in[0]};
      q_data.name_b     = {nb_in[7], nb_in[6], nb_in[5], nb_in[4]};
   end

   assign q_push = accept && done;

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         nb_ff[wr_idx] <= req_data.name_word;
      end
   end

endmodule

// File: src/hfpl_back.sv
// Back part: hashes, walks the bucket memories and produces response transfers.
// Depends on hfpl_pkg and hfpl_ram.
module hfpl_back #(
   parameter int BUCKETS      = 97,
   parameter int BUCKET_DEPTH = 64,
   parameter int NAME_BYTES   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  hfpl_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hfpl_pkg::rsp_type rsp_data
);

   localparam int HB    = $clog2(BUCKETS);
   localparam int RW    = HB + 1;
   localparam int CW    = $clog2(BUCKET_DEPTH + 1);
   localparam int SLOTS = BUCKETS * BUCKET_DEPTH;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NW    = NAME_BYTES * 8;
   localparam int HK    = 32 + HB;
   localparam logic [32:0] RECIP =
      33'(((64'd1 << HK) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_MOD  = 4'd2;
   localparam logic [3:0] S_CNT  = 4'd3;
   localparam logic [3:0] S_CNTW = 4'd4;
   localparam logic [3:0] S_RD   = 4'd5;
   localparam logic [3:0] S_CMP  = 4'd6;
   localparam logic [3:0] S_OUT  = 4'd7;
   localparam logic [3:0] S_REM  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   hfpl_pkg::cmd_type cmd_ff, cmd_in;
   logic [31:0]       val_ff, val_in;
   logic [31:0]       quo_ff, quo_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [31:0]       a_ff, a_in;
   logic [31:0]       b_ff, b_in;
   hfpl_pkg::rsp_type rsp_ff, rsp_in;
   logic [BUCKETS-1:0] pvld_ff, pvld_in;
   logic [BUCKETS-1:0] qvld_ff, qvld_in;

   logic [HB-1:0]   h;
   logic [31:0]     mul_x, mul_y;
   logic [45:0]     mprod;
   logic [64:0]     qprod;
   logic [31:0]     rem_full;
   logic [CW-1:0]   pcnt_rd, qcnt_rd, pcnt_now, qcnt_now, cnt_now;
   logic [CW-1:0]   slot_idx;
   logic [AW-1:0]   slot;
   logic [255:0]    qname;
   logic [31:0]     pid_rd;
   logic [NW-1:0]   pname_rd;
   logic [63:0]     pair_rd;
   logic            pair_walk, name_hit, pair_hit;
   logic            p_we, q_we;

   function automatic logic names_equal(input logic [NW-1:0] s, input logic [255:0] q);
      logic ok;
      logic stop;
      ok   = 1'b1;
      stop = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (!stop) begin
            if (s[i*8 +: 8] != q[i*8 +: 8]) begin
               ok = 1'b0;
            end
            stop = (s[i*8 +: 8] != q[i*8 +: 8]) || (s[i*8 +: 8] == 8'd0);
         end
      end
      return ok;
   endfunction

   assign h         = rem_ff[HB-1:0];
   assign pair_walk = (cmd_ff.kind == hfpl_pkg::KIND_PAIR) || phase_ff[1];
   assign qname     = phase_ff[0] ? cmd_ff.name_b : cmd_ff.name_a;
   assign pcnt_now  = pvld_ff[h] ? pcnt_rd : '0;
   assign qcnt_now  = qvld_ff[h] ? qcnt_rd : '0;
   assign cnt_now   = pair_walk ? qcnt_now : pcnt_now;
   assign slot_idx  = (state_ff == S_CNTW) ? cnt_now : idx_ff;
   assign slot      = AW'(32'(h) * 32'(BUCKET_DEPTH) + 32'(slot_idx));
   assign name_hit  = names_equal(pname_rd, qname);
   assign pair_hit  = ((pair_rd[31:0] == a_ff) && (pair_rd[63:32] == b_ff)) ||
                      ((pair_rd[31:0] == b_ff) && (pair_rd[63:32] == a_ff));
   assign mprod     = mul_x * hfpl_pkg::HASH_MUL;
   assign qprod     = 65'(val_ff) * 65'(RECIP);
   assign rem_full  = val_ff - quo_ff * 32'(BUCKETS);

   always_comb begin
      case (phase_ff)
         2'd2: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
         2'd3: begin
            mul_x = b_ff;
            mul_y = a_ff;
         end
         default: begin
            if (cmd_ff.kind == hfpl_pkg::KIND_PAIR) begin
               mul_x = cmd_ff.person_id;
               mul_y = cmd_ff.partner_id;
            end else begin
               mul_x = {24'd0, qname[7:0]};
               mul_y = {24'd0, qname[15:8]};
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      val_in   = val_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      rsp_in   = rsp_ff;
      pvld_in  = pvld_ff;
      qvld_in  = qvld_ff;
      q_pop    = 1'b0;
      p_we     = 1'b0;
      q_we     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               phase_in = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            val_in   = mprod[31:0] + mul_y;
            state_in = S_MOD;
         end
         S_MOD: begin
            quo_in   = 32'(qprod >> HK);
            state_in = S_REM;
         end
         S_REM: begin
            rem_in   = rem_full[RW-1:0];
            state_in = S_CNT;
         end
         S_CNT: begin
            state_in = S_CNTW;
         end
         S_CNTW: begin
            rsp_in.kind        = cmd_ff.kind;
            rsp_in.are_friends = 1'b0;
            rsp_in.status      = hfpl_pkg::ST_OK;
            if (cmd_ff.kind == hfpl_pkg::KIND_QUERY) begin
               n_in     = cnt_now;
               idx_in   = '0;
               state_in = S_RD;
            end else begin
               state_in = S_OUT;
               if (cnt_now >= CW'(BUCKET_DEPTH)) begin
                  rsp_in.status = hfpl_pkg::ST_FULL;
               end else if (cmd_ff.kind == hfpl_pkg::KIND_PAIR) begin
                  q_we        = 1'b1;
                  qvld_in[h]  = 1'b1;
               end else begin
                  p_we        = 1'b1;
                  pvld_in[h]  = 1'b1;
               end
            end
         end
         S_RD: begin
            if (idx_ff == n_ff) begin
               case (phase_ff)
                  2'd2: begin
                     phase_in = 2'd3;
                     state_in = S_MUL;
                  end
                  2'd3: begin
                     state_in = S_OUT;
                  end
                  default: begin
                     rsp_in.status = hfpl_pkg::ST_NOTFOUND;
                     state_in      = S_OUT;
                  end
               endcase
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            idx_in   = idx_ff + CW'(1);
            state_in = S_RD;
            case (phase_ff)
               2'd0: begin
                  if (name_hit) begin
                     a_in     = pid_rd;
                     phase_in = 2'd1;
                     state_in = S_MUL;
                  end
               end
               2'd1: begin
                  if (name_hit) begin
                     b_in     = pid_rd;
                     phase_in = 2'd2;
                     state_in = S_MUL;
                  end
               end
               default: begin
                  if (pair_hit) begin
                     rsp_in.are_friends = 1'b1;
                     state_in           = S_OUT;
                  end
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 2'd0;
         pvld_ff  <= '0;
         qvld_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pvld_ff  <= pvld_in;
         qvld_ff  <= qvld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      val_ff <= val_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      idx_ff <= idx_in;
      n_ff   <= n_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   hfpl_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_pcnt (
      .clock(clock), .we(p_we), .waddr(h), .wdata(cnt_now + CW'(1)),
      .raddr(h), .rdata(pcnt_rd)
   );

   hfpl_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_qcnt (
      .clock(clock), .we(q_we), .waddr(h), .wdata(cnt_now + CW'(1)),
      .raddr(h), .rdata(qcnt_rd)
   );

   hfpl_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_pid (
      .clock(clock), .we(p_we), .waddr(slot), .wdata(cmd_ff.person_id),
      .raddr(slot), .rdata(pid_rd)
   );

   hfpl_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_pname (
      .clock(clock), .we(p_we), .waddr(slot), .wdata(cmd_ff.name_a[NW-1:0]),
      .raddr(slot), .rdata(pname_rd)
   );

   hfpl_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_pair (
      .clock(clock), .we(q_we), .waddr(slot),
      .wdata({cmd_ff.partner_id, cmd_ff.person_id}),
      .raddr(slot), .rdata(pair_rd)
   );

endmodule

// File: src/hashed_friend_pair_lookup.sv
// Top level of the hashed friend pair lookup: front, command queue and back.
// Depends on hfpl_pkg, hfpl_front, hfpl_queue and hfpl_back.
//
// Name words and pairs enter at one transfer per cycle until the two-entry
// command queue fills; a name word that does not complete a name issues no
// command. The back takes one command at a time. Each hash is a multiply-add,
// a reciprocal multiply for the quotient and a multiply-subtract for the
// remainder, followed by a read of the bucket count; a person or pair store
// takes one hash. A query takes up to four hashes plus a read and a compare
// for each bucket entry compared, one entry per read of the bucket memories.
// Bucket fill counts have valid bits cleared at reset, so no clearing pass.
module hashed_friend_pair_lookup #(
   parameter int BUCKETS      = 97,
   parameter int BUCKET_DEPTH = 64,
   parameter int NAME_BYTES   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hfpl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hfpl_pkg::rsp_type rsp_data
);

   logic              q_full, q_push, q_pop, q_valid;
   hfpl_pkg::cmd_type q_in, q_out;

   hfpl_front u_front (
      .clock(clock), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   hfpl_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .out_valid(q_valid), .out_data(q_out)
   );

   hfpl_back #(
      .BUCKETS(BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH), .NAME_BYTES(NAME_BYTES)
   ) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("Command pushed into a full queue.");

   a_notfound_no: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == hfpl_pkg::ST_NOTFOUND) |-> !rsp_data.are_friends)
      else $error("Unknown name answered as friends.");

   a_store_no: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != hfpl_pkg::KIND_QUERY) |-> !rsp_data.are_friends)
      else $error("Store response carries a friend flag.");

   a_rsp_after_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !rsp_valid) else $error("Response shown before command was executed.");

endmodule

// File: test/tb_hashed_friend_pair_lookup.sv
// Self-checking testbench for the hashed friend pair lookup: a table of directed
// transfers, then random person, pair and query traffic under varied idling.
// Depends on hfpl_pkg and hashed_friend_pair_lookup.
module tb_hashed_friend_pair_lookup;

   localparam int BUCKETS = 97;
   localparam int DEPTH   = 64;
   localparam int NBYTES  = 32;
   localparam int NROWS   = 18;

   typedef struct {
      hfpl_pkg::req_type req;
      logic              check;
      hfpl_pkg::rsp_type rsp;
   } row_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   hfpl_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   hfpl_pkg::rsp_type rsp_data;

   int                send_idle = 0;
   int                recv_idle = 0;
   int                errors = 0;
   hfpl_pkg::rsp_type answers_due[$];

   int            person_count [BUCKETS];
   logic [31:0]   person_ids   [BUCKETS][DEPTH];
   logic [255:0]  person_names [BUCKETS][DEPTH];
   int            pair_count   [BUCKETS];
   logic [63:0]   pair_entries [BUCKETS][DEPTH];
   logic [63:0]   name_words   [8];

   logic [255:0]  known_names [$];
   logic [31:0]   known_ids [$];
   row_type       rows [NROWS];

   hashed_friend_pair_lookup i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic logic [7:0] name_byte(logic [255:0] n, int i);
      return n[i*8 +: 8];
   endfunction

   function automatic bit same_name(logic [255:0] a, logic [255:0] b);
      for (int i = 0; i < NBYTES; i++) begin
         if (name_byte(a, i) != name_byte(b, i)) return 0;
         if (name_byte(a, i) == 0) return 1;
      end
      return 1;
   endfunction

   function automatic int name_bucket(logic [255:0] n);
      logic [31:0] v;
      v = name_byte(n, 0) * 32'd10000 + name_byte(n, 1);
      return v % BUCKETS;
   endfunction

   function automatic int pair_bucket(logic [31:0] a, logic [31:0] b);
      logic [31:0] v;
      v = a * 32'd10000 + b;
      return v % BUCKETS;
   endfunction

   function automatic bit lookup_id(logic [255:0] n, output logic [31:0] id);
      int h;
      h = name_bucket(n);
      for (int i = 0; i < person_count[h]; i++)
         if (same_name(person_names[h][i], n)) begin
            id = person_ids[h][i];
            return 1;
         end
      return 0;
   endfunction

   function automatic bit bucket_holds(int h, logic [31:0] a, logic [31:0] b);
      for (int i = 0; i < pair_count[h]; i++)
         if ((pair_entries[h][i][31:0] == a && pair_entries[h][i][63:32] == b) ||
             (pair_entries[h][i][31:0] == b && pair_entries[h][i][63:32] == a))
            return 1;
      return 0;
   endfunction

   function automatic bit predict_answer(hfpl_pkg::req_type r,
                                         output hfpl_pkg::rsp_type rsp);
      int h;
      logic [255:0] na, nb;
      logic [31:0] a, b;
      rsp = '0;
      if (r.op == hfpl_pkg::OP_PERSON) begin
         name_words[r.word_index] = r.name_word;
         if (r.word_index != 3) return 0;
         na = {name_words[3], name_words[2], name_words[1], name_words[0]};
         h = name_bucket(na);
         rsp.kind = hfpl_pkg::KIND_PERSON;
         if (person_count[h] >= DEPTH) rsp.status = hfpl_pkg::ST_FULL;
         else begin
            person_ids[h][person_count[h]] = r.person_id;
            person_names[h][person_count[h]] = na;
            person_count[h]++;
         end
         return 1;
      end
      if (r.op == hfpl_pkg::OP_PAIR) begin
         h = pair_bucket(r.person_id, r.partner_id);
         rsp.kind = hfpl_pkg::KIND_PAIR;
         if (pair_count[h] >= DEPTH) rsp.status = hfpl_pkg::ST_FULL;
         else begin
            pair_entries[h][pair_count[h]] = {r.partner_id, r.person_id};
            pair_count[h]++;
         end
         return 1;
      end
      if (r.op == hfpl_pkg::OP_QUERY) begin
         name_words[4*r.which_name + r.word_index] = r.name_word;
         if (r.word_index != 3 || r.which_name != 1) return 0;
         na = {name_words[3], name_words[2], name_words[1], name_words[0]};
         nb = {name_words[7], name_words[6], name_words[5], name_words[4]};
         rsp.kind = hfpl_pkg::KIND_QUERY;
         if (!lookup_id(na, a) || !lookup_id(nb, b)) rsp.status = hfpl_pkg::ST_NOTFOUND;
         else rsp.are_friends = bucket_holds(pair_bucket(a, b), a, b) ||
                                bucket_holds(pair_bucket(b, a), a, b);
         return 1;
      end
      return 0;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("error: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) report_mismatch("unexpected transfer", 1, 0);
         else begin
            if (rsp_data.kind != answers_due[0].kind)
               report_mismatch("kind", rsp_data.kind, answers_due[0].kind);
            if (rsp_data.status != answers_due[0].status)
               report_mismatch("status", rsp_data.status, answers_due[0].status);
            if (rsp_data.are_friends != answers_due[0].are_friends)
               report_mismatch("are_friends", rsp_data.are_friends,
                               answers_due[0].are_friends);
            void'(answers_due.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic send_item(hfpl_pkg::req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_checked(hfpl_pkg::req_type r);
      hfpl_pkg::rsp_type p;
      if (predict_answer(r, p)) answers_due.push_back(p);
      send_item(r);
   endtask

   function automatic hfpl_pkg::req_type word_req(logic [1:0] op, logic [31:0] id,
                                                  logic [255:0] n, int w, logic which);
      hfpl_pkg::req_type r;
      r = '0;
      r.op = op;
      r.person_id = id;
      r.partner_id = $urandom;
      r.name_word = n[w*64 +: 64];
      r.word_index = 2'(w);
      r.which_name = which;
      return r;
   endfunction

   task automatic send_name(logic [1:0] op, logic [31:0] id, logic [255:0] n,
                            logic which);
      int order [4];
      int j, t;
      order = '{0, 1, 2, 3};
      for (int i = 0; i < 3; i++) begin
         j = $urandom_range(2, i);
         t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (int i = 0; i < 4; i++) send_checked(word_req(op, id, n, order[i], which));
   endtask

   function automatic logic [255:0] random_name();
      logic [255:0] n;
      int len;
      n = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
      len = $urandom_range(3) == 0 ? NBYTES : $urandom_range(NBYTES - 1, 1);
      for (int i = len; i < NBYTES; i++) n[i*8 +: 8] = 8'd0;
      if ($urandom_range(3) == 0) n[15:0] = 16'h4141;
      return n;
   endfunction

   task automatic random_traffic(int count);
      int k, i1, i2;
      hfpl_pkg::req_type r;
      logic [255:0] n;
      logic [31:0] id;
      for (int s = 0; s < count; s++) begin
         k = $urandom_range(99);
         if (k < 30) begin
            n = random_name();
            id = $urandom;
            known_names.push_back(n);
            known_ids.push_back(id);
            send_name(hfpl_pkg::OP_PERSON, id, n, 1'b0);
         end else if (k < 55 && known_ids.size() > 1) begin
            r = '0;
            r.op = hfpl_pkg::OP_PAIR;
            r.person_id = known_ids[$urandom_range(known_ids.size() - 1)];
            r.partner_id = known_ids[$urandom_range(known_ids.size() - 1)];
            if ($urandom_range(7) == 0) r.partner_id = $urandom;
            r.name_word = {$urandom, $urandom};
            r.word_index = 2'($urandom);
            r.which_name = 1'($urandom);
            send_checked(r);
         end else if (k < 90 && known_names.size() > 0) begin
            i1 = $urandom_range(known_names.size() - 1);
            i2 = $urandom_range(known_names.size() - 1);
            n = $urandom_range(5) == 0 ? random_name() : known_names[i1];
            send_name(hfpl_pkg::OP_QUERY, $urandom, n, 1'b0);
            send_name(hfpl_pkg::OP_QUERY, $urandom, known_names[i2], 1'b1);
         end else begin
            r = '0;
            r.op = hfpl_pkg::OP_UNUSED;
            r.person_id = $urandom;
            r.partner_id = $urandom;
            r.name_word = {$urandom, $urandom};
            r.word_index = 2'($urandom);
            r.which_name = 1'($urandom);
            send_checked(r);
         end
      end
   endtask

   initial begin
      #4000000;
      $display("hashed_friend_pair_lookup: mismatch");
      $finish;
   end

   initial begin
      logic [255:0] ones, a_name, b_name;
      hfpl_pkg::rsp_type p;
      int limit;
      for (int h = 0; h < BUCKETS; h++) begin
         person_count[h] = 0;
         pair_count[h] = 0;
      end
      foreach (name_words[i]) name_words[i] = '0;
      ones = '1;
      a_name = 256'h6f6c41;
      b_name = 256'h626f42;
      for (int i = 0; i < NROWS; i++) begin
         rows[i].check = 0;
         rows[i].rsp = '0;
      end
      rows[0].req = word_req(hfpl_pkg::OP_PERSON, '1, ones, 0, 1'b0);
      rows[1].req = word_req(hfpl_pkg::OP_PERSON, '1, ones, 1, 1'b0);
      rows[2].req = word_req(hfpl_pkg::OP_PERSON, '1, ones, 2, 1'b0);
      rows[3].req = word_req(hfpl_pkg::OP_PERSON, '1, ones, 3, 1'b0);
      rows[3].check = 1;
      rows[3].rsp = '{hfpl_pkg::KIND_PERSON, hfpl_pkg::ST_OK, 1'b0};
      rows[4].req = word_req(hfpl_pkg::OP_PERSON, 32'd0, a_name, 0, 1'b0);
      rows[5].req = word_req(hfpl_pkg::OP_PERSON, 32'd0, a_name, 1, 1'b0);
      rows[6].req = word_req(hfpl_pkg::OP_PERSON, 32'd0, a_name, 2, 1'b0);
      rows[7].req = word_req(hfpl_pkg::OP_PERSON, 32'd0, a_name, 3, 1'b0);
      rows[8].req = '{hfpl_pkg::OP_PAIR, 32'hffffffff, 32'd0, 64'd0, 2'd0, 1'b0};
      rows[8].check = 1;
      rows[8].rsp = '{hfpl_pkg::KIND_PAIR, hfpl_pkg::ST_OK, 1'b0};
      rows[9].req = word_req(hfpl_pkg::OP_QUERY, 32'd0, a_name, 0, 1'b0);
      rows[10].req = word_req(hfpl_pkg::OP_QUERY, 32'd0, a_name, 1, 1'b0);
      rows[11].req = word_req(hfpl_pkg::OP_QUERY, 32'd0, a_name, 2, 1'b0);
      rows[12].req = word_req(hfpl_pkg::OP_QUERY, 32'd0, a_name, 3, 1'b0);
      rows[13].req = word_req(hfpl_pkg::OP_QUERY, 32'd0, b_name, 0, 1'b1);
      rows[14].req = word_req(hfpl_pkg::OP_QUERY, 32'd0, b_name, 1, 1'b1);
      rows[15].req = word_req(hfpl_pkg::OP_QUERY, 32'd0, b_name, 2, 1'b1);
      rows[16].req = word_req(hfpl_pkg::OP_QUERY, 32'd0, b_name, 3, 1'b1);
      rows[16].check = 1;
      rows[16].rsp = '{hfpl_pkg::KIND_QUERY, hfpl_pkg::ST_NOTFOUND, 1'b0};
      rows[17].req = '{hfpl_pkg::OP_UNUSED, '1, '1, '1, 2'd3, 1'b1};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int i = 0; i < NROWS; i++) begin
         if (predict_answer(rows[i].req, p)) begin
            if (rows[i].check && p != rows[i].rsp)
               report_mismatch("directed row", i, 0);
            answers_due.push_back(rows[i].check ? rows[i].rsp : p);
         end
         send_item(rows[i].req);
      end
      b_name = ones;
      send_name(hfpl_pkg::OP_QUERY, 32'd0, b_name, 1'b0);
      send_name(hfpl_pkg::OP_QUERY, 32'd0, a_name, 1'b1);
      for (int i = 0; i < 70; i++)
         send_checked('{hfpl_pkg::OP_PAIR, 32'd0, 32'(97 * i), 64'd0, 2'd0, 1'b0});
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 17 : 83) : 0;
         recv_idle = (ph == 2 || ph == 3) ? (ph == 3 ? 17 : 83) : 0;
         random_traffic(75);
      end
      req_valid <= 1'b0;
      limit = 0;
      while (answers_due.size() != 0 && limit < 200000) begin
         @(posedge clock);
         limit++;
      end
      repeat (1000) @(posedge clock);
      if (errors == 0 && answers_due.size() == 0)
         $display("hashed_friend_pair_lookup: match");
      else
         $display("hashed_friend_pair_lookup: mismatch");
      $finish;
   end
endmodule

// File: files.f
src/hfpl_pkg.sv
src/hfpl_ram.sv
src/hfpl_queue.sv
src/hfpl_front.sv
src/hfpl_back.sv
src/hashed_friend_pair_lookup.sv
test/tb_hashed_friend_pair_lookup.sv
